### sv/sssd_pkg.sv
// package: constants and segment font for the seven-segment scan driver
`default_nettype none

package sssd_pkg;

  localparam int unsigned ValueW = 14;
  localparam int unsigned DigitW = 4;
  localparam int unsigned PosW   = 3;
  localparam int unsigned SegW   = 8;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [ValueW-1:0] ValueMax = 14'd9999;

  // reciprocal constants for division by 1000, 100 and 10 over 0..9999
  localparam logic [14:0] RecipThou  = 15'd16778;
  localparam int unsigned ShiftThou  = 24;
  localparam logic [13:0] RecipHund  = 14'd10486;
  localparam int unsigned ShiftHund  = 20;
  localparam logic [13:0] RecipTens  = 14'd13108;
  localparam int unsigned ShiftTens  = 17;

  localparam logic [DigitW-1:0] DigitBlank = 4'd10;

  localparam logic [PosW-1:0] PosOnes  = 3'd0;
  localparam logic [PosW-1:0] PosTens  = 3'd1;
  localparam logic [PosW-1:0] PosColon = 3'd2;
  localparam logic [PosW-1:0] PosHund  = 3'd3;
  localparam logic [PosW-1:0] PosThou  = 3'd4;

  localparam logic [SegW-1:0] SegBlank     = 8'hFF;
  localparam logic [SegW-1:0] SegPointMask = 8'h7F;
  localparam logic [SegW-1:0] ColonOnlyPat = 8'hFC;
  localparam logic [SegW-1:0] ColonAllPat  = 8'hF8;
  localparam logic [SegW-1:0] DotOnlyPat   = 8'hFB;
  localparam logic [SegW-1:0] DotBitMask   = 8'h04;

  localparam logic [CfgIdxW-1:0] CfgZeroFill  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgDecPoint  = 2'd1;

  function automatic logic [SegW-1:0] digit_font(input logic [DigitW-1:0] d);
    logic [SegW-1:0] s;
    begin
      case (d)
        4'd0:    s = 8'hC0;
        4'd1:    s = 8'hF9;
        4'd2:    s = 8'hA4;
        4'd3:    s = 8'hB0;
        4'd4:    s = 8'h99;
        4'd5:    s = 8'h92;
        4'd6:    s = 8'h83;
        4'd7:    s = 8'hF8;
        4'd8:    s = 8'h80;
        4'd9:    s = 8'h98;
        default: s = SegBlank;
      endcase
      return s;
    end
  endfunction

endpackage

`default_nettype wire

### sv/seven_segment_scan_driver.sv
// top level: four-digit multiplexed seven-segment scan driver
//
// Each input item is one refresh tick carrying a value (clamped to 9999)
// and colon controls. Each tick yields one result item: the scan position
// shown (ones, tens, colon, hundreds, thousands, repeating) and its
// active-low segment byte. Input and result channels use valid/stall.
// The result passes through an input register, then digit split,
// blanking and font lookup into the result register.
// Throughput is one item per cycle while the result is not stalled;
// the split uses three parallel reciprocal multiplies, which set the
// cycle's logic depth.
// A stalled result stays put; the input register still takes one more
// item, after which in_stall_o rises until the result is taken.
// Config writes (cfg_valid_i/cfg_ready_o, always ready) set zero_fill and
// decimal_point_on; do so only while no item is in flight.
// Reset clears both registers, the scan to the ones position and the
// colon pattern to colon only lit; no items are held after reset.
`default_nettype none

module seven_segment_scan_driver import sssd_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output      logic               in_stall_o,
  input  wire logic [ValueW-1:0]  value_i,
  input  wire logic               colon_update_i,
  input  wire logic               colon_off_i,
  input  wire logic               colon_full_i,
  input  wire logic               dot_toggle_i,
  output      logic               out_valid_o,
  input  wire logic               out_stall_i,
  output      logic [PosW-1:0]    position_select_o,
  output      logic [SegW-1:0]    segment_bits_o,
  input  wire logic               cfg_valid_i,
  output      logic               cfg_ready_o,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic               cfg_data_i
);

  logic              in_vld_q;
  logic [ValueW-1:0] val_q;
  logic              cupd_q, coff_q, call_q, dtog_q;
  logic              out_vld_q;
  logic [PosW-1:0]   pos_out_q;
  logic [SegW-1:0]   seg_out_q;
  logic [PosW-1:0]   scan_pos_q, scan_pos_d;
  logic [SegW-1:0]   colon_pat_q, colon_pat_d;
  logic              zero_fill_q, dec_point_q;

  logic out_free, move, load_in;

  assign out_free   = !out_vld_q || !out_stall_i;
  assign move       = in_vld_q && out_free;
  assign in_stall_o = in_vld_q && !out_free;
  assign load_in    = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  // digit split, blanking, colon pattern, segment lookup and next scan position
  logic [28:0]       prod_thou;
  logic [27:0]       prod_hund, prod_tens;
  logic [DigitW-1:0] thou, hund, tens, ones;
  logic [DigitW-1:0] thou_b, hund_b, tens_b;
  logic [6:0]        q100;
  logic [9:0]        q10;
  logic [6:0]        thou_x10;
  logic [9:0]        q100_x10;
  logic [ValueW-1:0] q10_x10;
  logic [6:0]        hund_w;
  logic [9:0]        tens_w;
  logic [ValueW-1:0] ones_w;
  logic [SegW-1:0]   seg_d;

  always_comb begin
    prod_thou = {14'd0, val_q} * {14'd0, RecipThou};
    prod_hund = {14'd0, val_q} * {14'd0, RecipHund};
    prod_tens = {14'd0, val_q} * {14'd0, RecipTens};
    thou = prod_thou[ShiftThou +: DigitW];
    q100 = prod_hund[ShiftHund +: 7];
    q10  = prod_tens[ShiftTens +: 10];
    thou_x10 = {thou, 3'b000} + {2'b00, thou, 1'b0};
    q100_x10 = {q100, 3'b000} + {2'b00, q100, 1'b0};
    q10_x10  = {1'b0, q10, 3'b000} + {3'b000, q10, 1'b0};
    hund_w = q100 - thou_x10;
    tens_w = q10 - q100_x10;
    ones_w = val_q - q10_x10;
    hund = hund_w[DigitW-1:0];
    tens = tens_w[DigitW-1:0];
    ones = ones_w[DigitW-1:0];

    thou_b = thou;
    hund_b = hund;
    tens_b = tens;
    if (!zero_fill_q && thou == 4'd0) begin
      thou_b = DigitBlank;
      if (hund == 4'd0) begin
        hund_b = DigitBlank;
        if (tens == 4'd0) begin
          tens_b = DigitBlank;
        end
      end
    end

    colon_pat_d = colon_pat_q;
    if (cupd_q) begin
      if (!coff_q) begin
        colon_pat_d = call_q ? ColonAllPat : ColonOnlyPat;
      end else begin
        colon_pat_d = call_q ? DotOnlyPat : SegBlank;
      end
    end
    if (dtog_q) begin
      colon_pat_d = colon_pat_d ^ DotBitMask;
    end

    case (scan_pos_q)
      PosOnes:  seg_d = digit_font(ones);
      PosTens:  seg_d = dec_point_q ? (digit_font(tens_b) & SegPointMask)
                                    : digit_font(tens_b);
      PosColon: seg_d = colon_pat_d;
      PosHund:  seg_d = digit_font(hund_b);
      PosThou:  seg_d = digit_font(thou_b);
      default:  seg_d = SegBlank;
    endcase

    scan_pos_d = (scan_pos_q >= PosThou) ? PosOnes : scan_pos_q + 3'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q    <= 1'b0;
      out_vld_q   <= 1'b0;
      scan_pos_q  <= PosOnes;
      colon_pat_q <= ColonOnlyPat;
      zero_fill_q <= 1'b0;
      dec_point_q <= 1'b0;
    end else begin
      if (load_in) begin
        in_vld_q <= 1'b1;
      end else if (move) begin
        in_vld_q <= 1'b0;
      end
      if (move) begin
        out_vld_q   <= 1'b1;
        scan_pos_q  <= scan_pos_d;
        colon_pat_q <= colon_pat_d;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CfgZeroFill) begin
          zero_fill_q <= cfg_data_i;
        end else if (cfg_index_i == CfgDecPoint) begin
          dec_point_q <= cfg_data_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_in) begin
      val_q  <= (value_i > ValueMax) ? ValueMax : value_i;
      cupd_q <= colon_update_i;
      coff_q <= colon_off_i;
      call_q <= colon_full_i;
      dtog_q <= dot_toggle_i;
    end
    if (move) begin
      pos_out_q <= scan_pos_q;
      seg_out_q <= seg_d;
    end
  end

  assign out_valid_o       = out_vld_q;
  assign position_select_o = pos_out_q;
  assign segment_bits_o    = seg_out_q;

  a_scan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_pos_q <= PosThou)
    else $error("scan position out of range");

  a_pos_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    move |=> position_select_o == $past(scan_pos_q))
    else $error("result position does not follow scan");

  a_colon_seg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && position_select_o == PosColon |-> segment_bits_o == colon_pat_q)
    else $error("colon result differs from colon pattern");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_vld_q && out_vld_q)
    else $error("input stalled with free pipeline");

endmodule

`default_nettype wire

### verif/display_checker.sv
// checker: predicts the scan driver's frames from the accepted items and compares them
`default_nettype none

module display_checker
  import sssd_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  wire logic               in_stall_i,
  input  wire logic [ValueW-1:0]  value_i,
  input  wire logic               colon_update_i,
  input  wire logic               colon_off_i,
  input  wire logic               colon_full_i,
  input  wire logic               dot_toggle_i,
  input  wire logic               out_valid_i,
  input  wire logic               out_stall_i,
  input  wire logic [PosW-1:0]    position_select_i,
  input  wire logic [SegW-1:0]    segment_bits_i,
  input  wire logic               cfg_valid_i,
  input  wire logic               cfg_ready_i,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic               cfg_data_i,
  output int                      fail_count_o,
  output int                      pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [PosW-1:0] pos;
    logic [SegW-1:0] seg;
  } frame_t;

  localparam logic [SegW-1:0] DigitGlyph [10] = '{
    8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h83, 8'hF8, 8'h80, 8'h98
  };

  logic            zero_fill = 1'b0;
  logic            point_on  = 1'b0;
  logic [PosW-1:0] scan_pos  = PosOnes;
  logic [SegW-1:0] colon_pat = ColonOnlyPat;
  frame_t          expected_frames [$];
  int              fails  = 0;
  int              queued = 0;

  assign fail_count_o = fails;
  assign pending_o    = queued;

  function automatic logic [SegW-1:0] digit_glyph(input int d, input bit blank);
    return blank ? SegBlank : DigitGlyph[d];
  endfunction

  task automatic refresh_display(input logic [ValueW-1:0] v, input logic upd,
                                 input logic off, input logic all, input logic tog,
                                 output frame_t f);
    int n, ones, tens, hund, thou;
    bit blank_thou, blank_hund, blank_tens;
    n = (v > ValueMax) ? int'(ValueMax) : int'(v);
    ones = n % 10;
    tens = (n / 10) % 10;
    hund = (n / 100) % 10;
    thou = n / 1000;
    blank_thou = !zero_fill && (thou == 0);
    blank_hund = blank_thou && (hund == 0);
    blank_tens = blank_hund && (tens == 0);
    if (upd) begin
      if (off) colon_pat = all ? DotOnlyPat : SegBlank;
      else colon_pat = all ? ColonAllPat : ColonOnlyPat;
    end
    if (tog) colon_pat = colon_pat ^ DotBitMask;
    f.pos = scan_pos;
    case (scan_pos)
      PosOnes: f.seg = digit_glyph(ones, 1'b0);
      PosTens: f.seg = digit_glyph(tens, blank_tens) & (point_on ? SegPointMask : SegBlank);
      PosColon: f.seg = colon_pat;
      PosHund: f.seg = digit_glyph(hund, blank_hund);
      PosThou: f.seg = digit_glyph(thou, blank_thou);
      default: f.seg = SegBlank;
    endcase
    scan_pos = (scan_pos >= PosThou) ? PosOnes : scan_pos + 1'b1;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track
    frame_t want, next;
    if (!rst_ni) begin
      zero_fill = 1'b0;
      point_on  = 1'b0;
      scan_pos  = PosOnes;
      colon_pat = ColonOnlyPat;
      expected_frames.delete();
    end else begin
      if (out_valid_i === 1'b1 && out_stall_i === 1'b0) begin
        if (expected_frames.size() == 0) begin
          fails++;
          $display("%0t: result item with none expected, position_select %0d segment_bits %h",
                   $time, position_select_i, segment_bits_i);
        end else begin
          want = expected_frames.pop_front();
          if (position_select_i !== want.pos) begin
            fails++;
            $display("%0t: position_select expected %0d, got %0d",
                     $time, want.pos, position_select_i);
          end
          if (segment_bits_i !== want.seg) begin
            fails++;
            $display("%0t: segment_bits at position %0d expected %h, got %h",
                     $time, want.pos, want.seg, segment_bits_i);
          end
        end
      end
      if (in_valid_i === 1'b1 && in_stall_i === 1'b0) begin
        refresh_display(value_i, colon_update_i, colon_off_i, colon_full_i, dot_toggle_i, next);
        expected_frames.push_back(next);
      end
      if (cfg_valid_i === 1'b1 && cfg_ready_i === 1'b1) begin
        case (cfg_index_i)
          CfgZeroFill: zero_fill = cfg_data_i;
          CfgDecPoint: point_on  = cfg_data_i;
          default: ;
        endcase
      end
    end
    queued = expected_frames.size();
  end

endmodule

`default_nettype wire

### verif/testbench.sv
// testbench top: stimulus, receiver stalls, watchdog and verdict for the scan driver
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import sssd_pkg::*;

  localparam int StallLimit = 2000;
  localparam logic [CfgIdxW-1:0] CfgUnusedLo = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgUnusedHi = 2'd3;

  localparam logic [ValueW-1:0] DirectedValues [25] = '{
    14'd0, 14'd5, 14'd9999, 14'd10000, 14'd16383, 14'd1, 14'd0, 14'd10, 14'd100,
    14'd1000, 14'd7, 14'd9, 14'd99, 14'd999, 14'd9998, 14'd12345, 14'd8888, 14'd42,
    14'd0, 14'd3, 14'd1010, 14'd1, 14'd9999, 14'd16383, 14'd500
  };

  typedef enum logic [1:0] {StallNone, StallLight, StallHeavy, StallBlock} stall_mode_e;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [ValueW-1:0]  value = '0;
  logic               colon_update = 1'b0;
  logic               colon_off = 1'b0;
  logic               colon_full = 1'b0;
  logic               dot_toggle = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [PosW-1:0]    position_select;
  logic [SegW-1:0]    segment_bits;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic               cfg_data = 1'b0;
  int                 fail_count;
  int                 pending;

  stall_mode_e stall_mode = StallNone;
  int          stall_run  = 0;
  logic [7:0]  stall_tick = '0;
  int          burst_left = 0;

  always #5 clk = ~clk;

  seven_segment_scan_driver uut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .value_i           (value),
    .colon_update_i    (colon_update),
    .colon_off_i       (colon_off),
    .colon_full_i      (colon_full),
    .dot_toggle_i      (dot_toggle),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .position_select_o (position_select),
    .segment_bits_o    (segment_bits),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_o       (cfg_ready),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data)
  );

  display_checker frame_check (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_stall_i        (in_stall),
    .value_i           (value),
    .colon_update_i    (colon_update),
    .colon_off_i       (colon_off),
    .colon_full_i      (colon_full),
    .dot_toggle_i      (dot_toggle),
    .out_valid_i       (out_valid),
    .out_stall_i       (out_stall),
    .position_select_i (position_select),
    .segment_bits_i    (segment_bits),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_i       (cfg_ready),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data),
    .fail_count_o      (fail_count),
    .pending_o         (pending)
  );

  always @(negedge clk) begin : stall_gen
    logic hold;
    if (stall_run == 0) begin
      stall_mode = stall_mode_e'($urandom_range(0, 3));
      stall_run  = $urandom_range(20, 200);
    end
    stall_run--;
    stall_tick++;
    case (stall_mode)
      StallNone:  hold = 1'b0;
      StallLight: hold = ($urandom_range(0, 3) == 0);
      StallHeavy: hold = ($urandom_range(0, 3) != 0);
      default:    hold = stall_tick[3];
    endcase
    out_stall <= hold;
  end

  task automatic send_tick(input logic [ValueW-1:0] v, input logic [3:0] ctl);
    @(negedge clk);
    in_valid <= 1'b1;
    value    <= v;
    {colon_update, colon_off, colon_full, dot_toggle} <= ctl;
    do @(posedge clk); while (in_stall !== 1'b0);
  endtask

  task automatic pause_sender();
    int gap;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
    end
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic d);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  function automatic logic [ValueW-1:0] pick_value();
    case ($urandom_range(0, 9))
      0, 1: return ValueW'($urandom_range(0, 9));
      2: return ValueW'($urandom_range(0, 99));
      3: return ValueW'($urandom_range(0, 999));
      4: return ValueW'($urandom_range(10000, 16383));
      5: begin
        case ($urandom_range(0, 3))
          0: return '0;
          1: return ValueMax;
          2: return ValueMax + 1'b1;
          default: return '1;
        endcase
      end
      default: return ValueW'($urandom_range(0, 9999));
    endcase
  endfunction

  function automatic logic [3:0] pick_colon();
    logic [3:0] ctl;
    ctl[3] = ($urandom_range(0, 3) == 0);
    ctl[2] = 1'($urandom_range(0, 1));
    ctl[1] = 1'($urandom_range(0, 1));
    ctl[0] = ($urandom_range(0, 5) == 0);
    return ctl;
  endfunction

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    @(posedge rst_n);
    while (idle_cycles < StallLimit) begin
      @(posedge clk);
      if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall) ||
          (cfg_valid && cfg_ready === 1'b1))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("seven_segment_scan_driver regression: fail");
    $finish;
  end

  initial begin : stimulus
    logic zf, dp;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // blanking on, point on: covers the lit point over a blanked tens digit
    write_reg(CfgZeroFill, 1'b0);
    write_reg(CfgDecPoint, 1'b1);
    for (int k = 0; k < 25; k++) begin
      send_tick(DirectedValues[k], 4'(k));
      pause_sender();
    end
    drain();

    for (int phase = 0; phase < 8; phase++) begin
      if (phase < 4) begin
        zf = phase[1];
        dp = phase[0];
      end else begin
        zf = 1'($urandom_range(0, 1));
        dp = 1'($urandom_range(0, 1));
      end
      write_reg(CfgZeroFill, zf);
      write_reg(CfgDecPoint, dp);
      if (phase == 5) begin
        write_reg(CfgUnusedLo, 1'($urandom_range(0, 1)));
        write_reg(CfgUnusedHi, 1'($urandom_range(0, 1)));
      end
      repeat (103) begin
        send_tick(pick_value(), pick_colon());
        pause_sender();
      end
      drain();
    end

    repeat (16) @(negedge clk);
    if (fail_count == 0 && pending == 0)
      $display("seven_segment_scan_driver regression: pass");
    else
      $display("seven_segment_scan_driver regression: fail");
    $finish;
  end

endmodule

`default_nettype wire
